// ===== sv/mad_pkg.sv =====
// shared constants and types for the multichannel aligned delay
// no dependencies

package mad_pkg;

    // channel count is fixed by the per-channel ports of the top level
    localparam int CHANNELS        = 6;
    localparam int DELAY_BITS      = 12;
    localparam int MAX_DELAY_DEF   = 4096;
    localparam int SAMPLE_BITS_DEF = 24;

    // register map
    localparam int REG_ENABLE     = 0;
    localparam int REG_DELAY_BASE = 1;
    localparam int NUM_REGS       = CHANNELS + 1;
    localparam int DATA_BITS      = 32;
    localparam int ADDR_BITS      = $clog2(4 * NUM_REGS);
    localparam int IDX_BITS       = ADDR_BITS - 2;

    // control shared by all lanes
    typedef struct packed {
        logic accept;
        logic enable;
        logic wrapped;
    } lane_ctrl_t;

endpackage

// ===== sv/multichannel_aligned_delay.sv =====
// multichannel aligned delay: six channel lanes, each with its own ring ram
// output: a result item is valid in the cycle after its input item is accepted
// throughput: one item per cycle unless stalled; none the cycle after a config write
// reset: control state and write pointer to zero; ring contents are not cleared,
// a wrap flag makes never-written entries read as zero, so no clearing pass is run
// depends on mad_pkg, mad_cfg, mad_lane, mad_ram

module multichannel_aligned_delay
    import mad_pkg::*;
#(
    parameter int MAX_DELAY   = MAX_DELAY_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_BITS-1:0]          paddr,
    input  logic [DATA_BITS-1:0]          pwdata,
    output logic [DATA_BITS-1:0]          prdata,
    output logic                          pready,
    // input frames
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_ch0,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_ch1,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_ch2,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_ch3,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_ch4,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_ch5,
    // delayed frames
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_out_ch0,
    output logic signed [SAMPLE_BITS-1:0] m_out_ch1,
    output logic signed [SAMPLE_BITS-1:0] m_out_ch2,
    output logic signed [SAMPLE_BITS-1:0] m_out_ch3,
    output logic signed [SAMPLE_BITS-1:0] m_out_ch4,
    output logic signed [SAMPLE_BITS-1:0] m_out_ch5
);

    localparam int AW = $clog2(MAX_DELAY);

    logic                   enable;
    logic                   settle;
    logic [AW-1:0]          rel      [CHANNELS];
    logic [SAMPLE_BITS-1:0] lane_in  [CHANNELS];
    logic [SAMPLE_BITS-1:0] lane_out [CHANNELS];
    lane_ctrl_t             ctrl;
    logic                   accept;

    // shared ring write pointer and the flag that marks the first wrap
    logic [AW-1:0]          wp_reg, wp_next;
    logic                   wrapped_reg, wrapped_next;
    // result stage: ram read data and per-lane select registers hold the item
    logic                   m_valid_reg, m_valid_next;

    assign pready = 1'b1;

    // registers, and the minimum over all channel delays
    mad_cfg #(
        .MAX_DELAY (MAX_DELAY)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .enable  (enable),
        .settle  (settle),
        .rel     (rel)
    );

    // new item may enter while the result stage drains in the same cycle;
    // the cycle after a config write is held off so relative delays can settle
    assign s_ready = !settle && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    assign ctrl.accept  = accept;
    assign ctrl.enable  = enable;
    assign ctrl.wrapped = wrapped_reg;

    always_comb begin
        wp_next      = wp_reg;
        wrapped_next = wrapped_reg;
        // disabled items leave the pointer and the rings untouched
        if (accept && enable) begin
            if (wp_reg == AW'(MAX_DELAY - 1)) begin
                wp_next      = '0;
                wrapped_next = 1'b1;
            end else begin
                wp_next = wp_reg + 1'b1;
            end
        end
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            wp_reg      <= wp_next;
            wrapped_reg <= wrapped_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign lane_in[0] = s_sample_ch0;
    assign lane_in[1] = s_sample_ch1;
    assign lane_in[2] = s_sample_ch2;
    assign lane_in[3] = s_sample_ch3;
    assign lane_in[4] = s_sample_ch4;
    assign lane_in[5] = s_sample_ch5;

    // one lane per channel, all sharing the write pointer
    for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
        mad_lane #(
            .MAX_DELAY   (MAX_DELAY),
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .aclk   (aclk),
            .ctrl   (ctrl),
            .wp     (wp_reg),
            .rel    (rel[ch]),
            .sample (lane_in[ch]),
            .result (lane_out[ch])
        );
    end

    assign m_valid   = m_valid_reg;
    assign m_out_ch0 = lane_out[0];
    assign m_out_ch1 = lane_out[1];
    assign m_out_ch2 = lane_out[2];
    assign m_out_ch3 = lane_out[3];
    assign m_out_ch4 = lane_out[4];
    assign m_out_ch5 = lane_out[5];

endmodule

// ===== sv/mad_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies

module mad_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/mad_cfg.sv =====
// register file and relative delay computation (minimum over all channels)
// depends on mad_pkg

module mad_cfg
    import mad_pkg::*;
#(
    parameter int MAX_DELAY = MAX_DELAY_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ADDR_BITS-1:0]         paddr,
    input  logic [DATA_BITS-1:0]         pwdata,
    output logic [DATA_BITS-1:0]         prdata,
    output logic                         enable,
    output logic                         settle,
    output logic [$clog2(MAX_DELAY)-1:0] rel [CHANNELS]
);

    localparam int AW = $clog2(MAX_DELAY);

    logic                         enable_reg, enable_next;
    logic                         settle_reg, settle_next;
    logic signed [DELAY_BITS-1:0] delay_reg  [CHANNELS];
    logic signed [DELAY_BITS-1:0] delay_next [CHANNELS];
    logic [AW-1:0]                rel_reg    [CHANNELS];
    logic [AW-1:0]                rel_next   [CHANNELS];
    logic signed [DELAY_BITS-1:0] lowest;
    logic signed [DELAY_BITS:0]   diff;
    logic [DELAY_BITS-1:0]        diff_u;
    logic [IDX_BITS-1:0]          idx;
    logic                         wr;

    assign idx = paddr[ADDR_BITS-1:2];
    assign wr  = psel && penable && pwrite;

    always_comb begin
        enable_next = enable_reg;
        delay_next  = delay_reg;
        settle_next = wr;
        if (wr) begin
            if (idx == IDX_BITS'(REG_ENABLE)) begin
                enable_next = pwdata[0];
            end
            for (int ch = 0; ch < CHANNELS; ch++) begin
                if (idx == IDX_BITS'(REG_DELAY_BASE + ch)) begin
                    delay_next[ch] = pwdata[DELAY_BITS-1:0];
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (idx == IDX_BITS'(REG_ENABLE)) begin
            prdata = DATA_BITS'(enable_reg);
        end
        for (int ch = 0; ch < CHANNELS; ch++) begin
            if (idx == IDX_BITS'(REG_DELAY_BASE + ch)) begin
                prdata = DATA_BITS'(unsigned'(delay_reg[ch]));
            end
        end
    end

    // relative delays, saturated to the ring size
    always_comb begin
        lowest = delay_reg[0];
        for (int ch = 1; ch < CHANNELS; ch++) begin
            if (delay_reg[ch] < lowest) begin
                lowest = delay_reg[ch];
            end
        end
        diff   = '0;
        diff_u = '0;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            diff   = {delay_reg[ch][DELAY_BITS-1], delay_reg[ch]} - {lowest[DELAY_BITS-1], lowest};
            diff_u = diff[DELAY_BITS-1:0];
            if (int'(diff_u) > MAX_DELAY - 1) begin
                rel_next[ch] = AW'(MAX_DELAY - 1);
            end else begin
                rel_next[ch] = AW'(diff_u);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            settle_reg <= 1'b0;
            for (int ch = 0; ch < CHANNELS; ch++) begin
                delay_reg[ch] <= '0;
                rel_reg[ch]   <= '0;
            end
        end else begin
            enable_reg <= enable_next;
            settle_reg <= settle_next;
            delay_reg  <= delay_next;
            rel_reg    <= rel_next;
        end
    end

    assign enable = enable_reg;
    assign settle = settle_reg;
    assign rel    = rel_reg;

endmodule

// ===== sv/mad_lane.sv =====
// one channel lane: ring ram, read address, bypass and zero-fill select
// depends on mad_pkg and mad_ram

module mad_lane
    import mad_pkg::*;
#(
    parameter int MAX_DELAY   = MAX_DELAY_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                         aclk,
    input  lane_ctrl_t                   ctrl,
    input  logic [$clog2(MAX_DELAY)-1:0] wp,
    input  logic [$clog2(MAX_DELAY)-1:0] rel,
    input  logic [SAMPLE_BITS-1:0]       sample,
    output logic [SAMPLE_BITS-1:0]       result
);

    localparam int AW = $clog2(MAX_DELAY);

    logic [AW:0]             rd_wrap;
    logic [AW-1:0]           rd;
    logic                    written;
    logic                    pass_reg, pass_next;
    logic                    zero_reg, zero_next;
    logic [SAMPLE_BITS-1:0]  sample_reg;
    logic [SAMPLE_BITS-1:0]  ram_q;

    always_comb begin
        rd_wrap = {1'b0, wp} + (AW+1)'(MAX_DELAY) - {1'b0, rel};
        if (wp >= rel) begin
            rd = wp - rel;
        end else begin
            rd = rd_wrap[AW-1:0];
        end
        // entries ahead of the write pointer are unwritten until the first wrap
        written   = ctrl.wrapped || (rd < wp);
        pass_next = !ctrl.enable || (rel == '0);
        zero_next = !written;
    end

    mad_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_DELAY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ctrl.accept && ctrl.enable),
        .waddr (wp),
        .wdata (sample),
        .re    (ctrl.accept),
        .raddr (rd),
        .rdata (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (ctrl.accept) begin
            pass_reg   <= pass_next;
            zero_reg   <= zero_next;
            sample_reg <= sample;
        end
    end

    always_comb begin
        if (pass_reg) begin
            result = sample_reg;
        end else if (zero_reg) begin
            result = '0;
        end else begin
            result = ram_q;
        end
    end

endmodule
